// File: rtl/crik_pkg.sv
// ----------------------------------------------------------------------------
// crik_pkg
// Shared constants, types and the arctangent table for the crossing reach
// and intent check.
// ----------------------------------------------------------------------------
package crik_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ANGLE_TABLE_LEN   = 24;
  // CORDIC datapath width: 25-bit deltas, gain and sqrt(2) growth
  localparam int CW                = 28;

  localparam logic [31:0] STOP_SPEED_SQ     = 32'd19600;
  localparam logic [15:0] HORIZON_UNLIMITED = 16'hFFFF;
  localparam logic [19:0] DIST_SCALE        = 20'd1000000;
  localparam logic [15:0] HALF_TURN         = 16'h8000;
  localparam logic [31:0] HALF_TURN_Z       = 32'h8000_0000;
  localparam logic [31:0] ROUND_Z           = 32'h0000_8000;

  typedef enum logic [7:0] {
    REG_MIN_SPEED   = 8'd0,
    REG_HEADING_TOL = 8'd1
  } reg_index_t;

  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/crik_cordic.sv
// ----------------------------------------------------------------------------
// crik_cordic
// Pipelined vectoring CORDIC: bearing of (x, y) as a 16-bit binary angle.
// One pre-rotation stage plus one register stage per iteration.
// ----------------------------------------------------------------------------
module crik_cordic #(
  parameter int STAGES = crik_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               advance,
  input  logic signed [24:0] x_in,
  input  logic signed [24:0] y_in,
  output logic [15:0]        bearing
);
  import crik_pkg::*;

  logic signed [CW-1:0] xs [0:STAGES];
  logic signed [CW-1:0] ys [0:STAGES];
  logic [31:0]          zs [0:STAGES];
  logic                 nz [0:STAGES];
  logic [31:0]          z_round;

  // left half-plane vectors are turned by a half turn first
  always_ff @(posedge clk) begin
    if (advance) begin
      nz[0] <= (x_in != '0) || (y_in != '0);
      if (x_in < 0) begin
        xs[0] <= -CW'(x_in);
        ys[0] <= -CW'(y_in);
        zs[0] <= HALF_TURN_Z;
      end else begin
        xs[0] <= CW'(x_in);
        ys[0] <= CW'(y_in);
        zs[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    always_ff @(posedge clk) begin
      if (advance) begin
        nz[g+1] <= nz[g];
        if (ys[g] >= 0) begin
          xs[g+1] <= xs[g] + (ys[g] >>> g);
          ys[g+1] <= ys[g] - (xs[g] >>> g);
          zs[g+1] <= zs[g] + atan_angle(5'(g));
        end else begin
          xs[g+1] <= xs[g] - (ys[g] >>> g);
          ys[g+1] <= ys[g] + (xs[g] >>> g);
          zs[g+1] <= zs[g] - atan_angle(5'(g));
        end
      end
    end
  end

  assign z_round = zs[STAGES] + ROUND_Z;
  assign bearing = nz[STAGES] ? z_round[31:16] : 16'h0;

endmodule

// File: rtl/crik_reach.sv
// ----------------------------------------------------------------------------
// crik_reach
// Reach test on squares (distance * 1000 < speed * horizon) and stop flag,
// four register stages followed by an alignment delay.
// ----------------------------------------------------------------------------
module crik_reach #(
  parameter int DELAY = crik_pkg::CORDIC_STAGES_DEF - 3
) (
  input  logic               clk,
  input  logic               advance,
  input  logic [14:0]        min_speed,
  input  logic signed [24:0] cx,
  input  logic signed [24:0] cy,
  input  logic [30:0]        vx_sq,
  input  logic [30:0]        vy_sq,
  input  logic [15:0]        horizon,
  output logic               reach,
  output logic               stopped
);
  import crik_pkg::*;

  logic signed [49:0] cxx_full, cyy_full;
  logic [31:0] s2;
  logic [48:0] cxx2, cyy2;
  logic [30:0] mh2_s;
  logic [31:0] hh2;
  logic        unl2;

  logic [49:0] d2_3;
  logic [61:0] mh2_3;
  logic [63:0] shh3;
  logic        unl3, unl_reach3, stop3;

  logic [44:0] lo4, hi4;
  logic [61:0] mh2_4;
  logic [63:0] shh4;
  logic        unl4, unl_reach4, stop4;

  logic [69:0] dm;
  logic        reach5, stop5;
  logic [1:0]  dly [0:DELAY];

  assign cxx_full = cx * cx;
  assign cyy_full = cy * cy;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2    <= 32'(vx_sq) + 32'(vy_sq);
      cxx2  <= cxx_full[48:0];
      cyy2  <= cyy_full[48:0];
      mh2_s <= 31'(min_speed) * 31'(horizon);
      hh2   <= 32'(horizon) * 32'(horizon);
      unl2  <= horizon == HORIZON_UNLIMITED;

      d2_3       <= 50'(cxx2) + 50'(cyy2);
      mh2_3      <= 62'(mh2_s) * 62'(mh2_s);
      shh3       <= 64'(s2) * 64'(hh2);
      unl3       <= unl2;
      unl_reach3 <= (min_speed != '0) || (s2 != '0);
      stop3      <= s2 < STOP_SPEED_SQ;

      // d2 * 10^6 in two 25-bit halves
      lo4        <= 45'(d2_3[24:0]) * 45'(DIST_SCALE);
      hi4        <= 45'(d2_3[49:25]) * 45'(DIST_SCALE);
      mh2_4      <= mh2_3;
      shh4       <= shh3;
      unl4       <= unl3;
      unl_reach4 <= unl_reach3;
      stop4      <= stop3;

      reach5 <= unl4 ? unl_reach4 : ((dm < 70'(mh2_4)) || (dm < 70'(shh4)));
      stop5  <= stop4;
    end
  end

  assign dm = {hi4, 25'h0} + 70'(lo4);

  assign dly[0] = {reach5, stop5};
  for (genvar g = 0; g < DELAY; g++) begin : g_dly
    always_ff @(posedge clk) begin
      if (advance) begin
        dly[g+1] <= dly[g];
      end
    end
  end

  assign reach   = dly[DELAY][1];
  assign stopped = dly[DELAY][0];

endmodule

// File: rtl/crosswalk_reach_intent_check.sv
// ----------------------------------------------------------------------------
// crosswalk_reach_intent_check
// Decides per item whether an object can reach a crossing and heads for it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one item per transfer; output
//   channel out_valid/out_stall returns one result per item, in order.
//   Configuration writes go through cfg_valid/cfg_ready (always ready) with
//   cfg_index 0 = min_speed, 1 = heading_tolerance; other indexes are dropped.
//   Write configuration only while no item is in flight.
// Path: input register, CORDIC pre-rotation and iteration registers, then the
//   relative-angle register and the output register before result valid.
// Throughput: one item per cycle unless stalled; three parallel bearing lanes.
// Stall: out_stall with out_valid high freezes the whole pipeline in the same
//   cycle and is reflected on in_stall; nothing is dropped or repeated.
// Reset: clears all valid bits, min_speed to 1000 and heading_tolerance to
//   8192. The block is ready on the cycle after reset.
// ----------------------------------------------------------------------------
module crosswalk_reach_intent_check #(
  parameter int CORDIC_STAGES = crik_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] obj_x,
  input  logic signed [23:0] obj_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic [15:0]        heading,
  input  logic signed [23:0] center_x,
  input  logic signed [23:0] center_y,
  input  logic signed [23:0] right_x,
  input  logic signed [23:0] right_y,
  input  logic signed [23:0] left_x,
  input  logic signed [23:0] left_y,
  input  logic [15:0]        horizon_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               can_reach,
  output logic               within_reach,
  output logic               heading_toward,
  output logic               is_stopped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import crik_pkg::*;

  localparam int LAT = CORDIC_STAGES + 4;

  logic [14:0] min_speed;
  logic [15:0] heading_tolerance;
  logic        vld [0:LAT-1];
  logic        advance;

  logic signed [24:0] cx1, cy1, rx1, ry1, lx1, ly1;
  logic [30:0]        vx_sq1, vy_sq1;
  logic [15:0]        h1, travel1;
  logic signed [31:0] vx_prod, vy_prod;
  // travel direction rides along the pre-rotation stage and every iteration
  logic [15:0]        trv [0:CORDIC_STAGES+1];

  logic [15:0] bc, br, bl;
  logic signed [15:0] rr, rl, rh, mn, mx;
  logic        reach_a, stop_a;
  logic        reach_b, stop_b;
  logic signed [16:0] dev;

  assign advance   = !(vld[LAT-1] && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed         <= 15'd1000;
      heading_tolerance <= 16'd8192;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_SPEED:   min_speed <= cfg_data[14:0];
        REG_HEADING_TOL: heading_tolerance <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (advance) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  assign vx_prod = vel_x * vel_x;
  assign vy_prod = vel_y * vel_y;

  always_ff @(posedge clk) begin
    if (advance) begin
      cx1    <= 25'(center_x) - 25'(obj_x);
      cy1    <= 25'(center_y) - 25'(obj_y);
      rx1    <= 25'(right_x) - 25'(obj_x);
      ry1    <= 25'(right_y) - 25'(obj_y);
      lx1    <= 25'(left_x) - 25'(obj_x);
      ly1    <= 25'(left_y) - 25'(obj_y);
      vx_sq1 <= vx_prod[30:0];
      vy_sq1 <= vy_prod[30:0];
      h1     <= horizon_ms;
      if (vel_x > 0) begin
        travel1 <= heading;
      end else if (vel_x < 0) begin
        travel1 <= heading + HALF_TURN;
      end else begin
        travel1 <= '0;
      end
    end
  end

  assign trv[0] = travel1;
  for (genvar g = 0; g < CORDIC_STAGES + 1; g++) begin : g_trv
    always_ff @(posedge clk) begin
      if (advance) begin
        trv[g+1] <= trv[g];
      end
    end
  end

  crik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_c (
    .clk(clk), .advance(advance), .x_in(cx1), .y_in(cy1), .bearing(bc)
  );
  crik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_r (
    .clk(clk), .advance(advance), .x_in(rx1), .y_in(ry1), .bearing(br)
  );
  crik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_l (
    .clk(clk), .advance(advance), .x_in(lx1), .y_in(ly1), .bearing(bl)
  );

  crik_reach #(.DELAY(CORDIC_STAGES - 3)) u_reach (
    .clk(clk), .advance(advance), .min_speed(min_speed),
    .cx(cx1), .cy(cy1), .vx_sq(vx_sq1), .vy_sq(vy_sq1), .horizon(h1),
    .reach(reach_a), .stopped(stop_a)
  );

  // angles relative to the center bearing, wrapped to signed 16 bits
  always_ff @(posedge clk) begin
    if (advance) begin
      rr      <= $signed(br - bc);
      rl      <= $signed(bl - bc);
      rh      <= $signed(trv[CORDIC_STAGES+1] - bc);
      reach_b <= reach_a;
      stop_b  <= stop_a;
    end
  end

  assign mn = (rr < rl) ? rr : rl;
  assign mx = (rr < rl) ? rl : rr;

  always_comb begin
    if (rh < mn) begin
      dev = 17'(mn) - 17'(rh);
    end else if (mx < rh) begin
      dev = 17'(rh) - 17'(mx);
    end else begin
      dev = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      within_reach   <= reach_b;
      is_stopped     <= stop_b;
      heading_toward <= $unsigned(dev) < {1'b0, heading_tolerance};
      can_reach      <= reach_b && (($unsigned(dev) < {1'b0, heading_tolerance}) || stop_b);
    end
  end

  assign out_valid = vld[LAT-1];

`ifndef SYNTH
  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> vld[0] == $past(vld[0]) && out_valid)
    else $error("pipeline moved during stall");
  a_stop_reach: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_stopped && within_reach |-> can_reach)
    else $error("stopped object in reach not flagged");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for crosswalk_reach_intent_check: it drives directed
// and random crossing geometry through the valid/stall channels under random
// idling, predicts verdicts with its own CORDIC model or takes typed-in ones,
// and checks every result in order, across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import crik_pkg::*;

  localparam int NSTAGE       = 16;
  localparam int DRAIN_CYC    = NSTAGE + 12;
  localparam int CYCLE_LIMIT  = 600000;
  localparam logic [7:0] REG_SPARE = 8'hA5;

  localparam logic [31:0] ATAN_Z [ANGLE_TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

  typedef struct packed {
    logic signed [23:0] ox, oy;
    logic signed [15:0] vx, vy;
    logic [15:0]        hd;
    logic signed [23:0] cx, cy, rx, ry, lx, ly;
    logic [15:0]        hz;
  } geom_t;

  typedef struct packed {
    logic can, reach, toward, stopped;
  } verdict_t;

  typedef struct {
    geom_t    g;
    logic     typed;
    verdict_t v;
  } row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [23:0] obj_x, obj_y, center_x, center_y, right_x, right_y, left_x, left_y;
  logic signed [15:0] vel_x, vel_y;
  logic [15:0] heading, horizon_ms;
  logic can_reach, within_reach, heading_toward, is_stopped;
  logic cfg_valid, cfg_ready;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;

  crosswalk_reach_intent_check u_dut (.*);

  logic [14:0] floor_speed;
  logic [15:0] tol_ang;
  verdict_t verdict_q[$];
  verdict_t typed_q[$];   // typed-in verdicts waiting for their transfer
  logic typed_pending[$];
  int fails, cycles;
  logic quiet;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] cordic_bearing(longint x, longint y);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN_Z;
    end
    for (int i = 0; i < NSTAGE && i < ANGLE_TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_Z[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_Z[i];
      end
    end
    z = z + ROUND_Z;
    return z[31:16];
  endfunction

  // d2 * 10^6 < r without overflow
  function automatic logic under_reach(longint unsigned d2, longint unsigned r);
    if (r == 0) return 1'b0;
    return d2 <= (r - 1) / 1000000;
  endfunction

  function automatic verdict_t predict_verdict(geom_t g);
    verdict_t v;
    longint cx, cy, rx, ry, lx, ly;
    longint unsigned s, d2, mh, h;
    logic [15:0] bc, br, bl, travel;
    logic signed [15:0] rr, rl, rh, mn, mx;
    int dev;
    cx = longint'(g.cx) - g.ox; cy = longint'(g.cy) - g.oy;
    rx = longint'(g.rx) - g.ox; ry = longint'(g.ry) - g.oy;
    lx = longint'(g.lx) - g.ox; ly = longint'(g.ly) - g.oy;
    s = longint'(g.vx) * g.vx + longint'(g.vy) * g.vy;
    h = 64'(g.hz);
    v.stopped = s < STOP_SPEED_SQ;
    if (g.hz == HORIZON_UNLIMITED) v.reach = (floor_speed != 0) || (s != 0);
    else begin
      d2 = cx * cx + cy * cy;
      mh = longint'(floor_speed) * h;
      v.reach = under_reach(d2, mh * mh) || under_reach(d2, s * (h * h));
    end
    bc = cordic_bearing(cx, cy);
    br = cordic_bearing(rx, ry);
    bl = cordic_bearing(lx, ly);
    if (g.vx > 0) travel = g.hd;
    else if (g.vx < 0) travel = g.hd + HALF_TURN;
    else travel = 16'd0;
    rr = br - bc;
    rl = bl - bc;
    rh = travel - bc;
    mn = rr < rl ? rr : rl;
    mx = rr < rl ? rl : rr;
    if (rh < mn) dev = int'(mn) - int'(rh);
    else if (mx < rh) dev = int'(rh) - int'(mx);
    else dev = 0;
    v.toward = dev < int'(tol_ang);
    v.can = v.reach && (v.toward || v.stopped);
    return v;
  endfunction

  // input transfers: record expectations
  always @(posedge clk) begin
    geom_t g;
    if (!rst && in_valid && !in_stall) begin
      g = '{obj_x, obj_y, vel_x, vel_y, heading, center_x, center_y,
            right_x, right_y, left_x, left_y, horizon_ms};
      if (typed_pending.size() > 0 && typed_pending.pop_front())
        verdict_q.insert(verdict_q.size(), typed_q.pop_front());
      else
        verdict_q.insert(verdict_q.size(), predict_verdict(g));
    end
  end

  // output transfers: compare
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
      end else begin
        e = verdict_q.pop_front();
        if (can_reach !== e.can) begin
          $error("can_reach exp %0b got %0b", e.can, can_reach); fails++;
        end
        if (within_reach !== e.reach) begin
          $error("within_reach exp %0b got %0b", e.reach, within_reach); fails++;
        end
        if (heading_toward !== e.toward) begin
          $error("heading_toward exp %0b got %0b", e.toward, heading_toward); fails++;
        end
        if (is_stopped !== e.stopped) begin
          $error("is_stopped exp %0b got %0b", e.stopped, is_stopped); fails++;
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_MIN_SPEED) floor_speed = val[14:0];
    else if (idx == REG_HEADING_TOL) tol_ang = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_item(geom_t g);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid = 1'b1;
    {obj_x, obj_y, vel_x, vel_y, heading, center_x, center_y,
     right_x, right_y, left_x, left_y, horizon_ms} = g;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic geom_t random_geom();
    geom_t g;
    int span;
    g = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom};
    if ($urandom_range(0, 9) < 2) return g;   // fully random fields
    span = 1 << $urandom_range(4, 21);
    g.cx = 24'(g.ox + $signed($urandom_range(0, 2 * span)) - span);
    g.cy = 24'(g.oy + $signed($urandom_range(0, 2 * span)) - span);
    g.rx = 24'(g.cx + $signed($urandom_range(0, span)) - span / 2);
    g.ry = 24'(g.cy + $signed($urandom_range(0, span)) - span / 2);
    g.lx = 24'(g.cx + $signed($urandom_range(0, span)) - span / 2);
    g.ly = 24'(g.cy + $signed($urandom_range(0, span)) - span / 2);
    case ($urandom_range(0, 3))
      0: begin g.vx = 16'($signed($urandom_range(0, 400)) - 200);
               g.vy = 16'($signed($urandom_range(0, 400)) - 200); end
      1: g.vy = 16'($signed($urandom_range(0, 600)) - 300);
      default: ;
    endcase
    case ($urandom_range(0, 4))
      0: g.hz = HORIZON_UNLIMITED;
      1: g.hz = 16'd0;
      2: g.hz = 16'($urandom_range(1, 20000));
      default: ;
    endcase
    return g;
  endfunction

  row_t dir_rows[$];

  initial begin
    logic [15:0] speeds[5] = '{16'd1000, 16'd0, 16'd32767, 16'd140, 16'd5000};
    logic [15:0] tols[5]   = '{16'd8192, 16'd0, 16'd32768, 16'd65535, 16'd2000};
    int per_phase;
    geom_t g;
    rst = 1'b1; in_valid = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    obj_x = '0; obj_y = '0; vel_x = '0; vel_y = '0; heading = '0;
    center_x = '0; center_y = '0; right_x = '0; right_y = '0;
    left_x = '0; left_y = '0; horizon_ms = '0;
    floor_speed = 15'd1000; tol_ang = 16'd8192;
    fails = 0; cycles = 0; quiet = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at reset settings
    g = '0;
    dir_rows.insert(dir_rows.size(), '{g, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1}});  // zero horizon
    g.hz = HORIZON_UNLIMITED;
    dir_rows.insert(dir_rows.size(), '{g, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b1}});  // unlimited
    g = '0; g.vx = 16'sd139;
    dir_rows.insert(dir_rows.size(), '{g, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1}});
    g = '0; g.vx = 16'sd140;
    dir_rows.insert(dir_rows.size(), '{g, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0}});
    g = '{24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 24'sh800000,
          24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFE};
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});
    g = '{24'sh800000, 24'sh7FFFFF, 16'sh8000, 16'sh7FFF, 16'h0000, 24'sh7FFFFF,
          24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'h0001};
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});
    g = '0; g.vx = -16'sd2000; g.hd = 16'h4000; g.cx = 24'sd3000; g.rx = 24'sd3000;
    g.ry = -24'sd500; g.lx = 24'sd3000; g.ly = 24'sd500; g.hz = 16'd1500;
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});              // backing away
    g.vx = 16'sd2000;
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});              // forward
    g.hd = 16'h8000;
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});              // facing away
    g.cx = -24'sd3000; g.cy = 24'sd1;                            // center near -pi
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});
    g.cx = 24'sd0; g.cy = 24'sd0; g.rx = 24'sd0; g.ry = 24'sd0;  // zero vectors
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});
    g = '0; g.vy = 16'sd3000; g.cx = 24'sd2999; g.hz = 16'd1000;  // lateral only
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});
    g.cx = 24'sd3000;
    dir_rows.insert(dir_rows.size(), '{g, 1'b0, '0});
    foreach (dir_rows[i]) begin
      typed_pending.insert(typed_pending.size(), dir_rows[i].typed);
      if (dir_rows[i].typed) typed_q.insert(typed_q.size(), dir_rows[i].v);
      send_item(dir_rows[i].g);
    end
    drain();

    per_phase = 280;
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_MIN_SPEED, speeds[p]);
      write_reg(REG_HEADING_TOL, tols[p]);
      if (p == 2) write_reg(REG_SPARE, 16'h1234);   // dropped by the block
      if (p == 4) quiet = 1'b1;
      for (int n = 0; n < per_phase; n++) begin
        if (p == 1 && n == 100) drain();
        send_item(random_geom());
      end
      drain();
    end

    if (fails == 0 && verdict_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
